>>> rtl/gshd_pkg.sv
// Shared types, fixed-point constants and scaling helpers for the gyro step
// and heading detector. Depends on nothing; every other file but gshd_ram uses it by scope.
package gshd_pkg;

    localparam int RAW_W      = 16;
    localparam int SMP_W      = 5;
    localparam int SMP_MAG    = 16;
    localparam int FRAC_W     = 8;
    localparam int Q_W        = 13;
    localparam int AVG_W      = 14;
    localparam int OFF_W      = 13;
    localparam int THR_W      = 8;
    localparam int RD_W       = 15;
    localparam int PROD_W     = 28;
    localparam int RS_W       = 16;
    localparam int SCALE_SH   = 12;
    localparam int HEAD_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic signed [14:0] SCALE_Q12 = 15'sd8419;
    localparam int                 DT6_Q32   = 6015360;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_THRESHOLD = 3'd5;

    localparam logic signed [THR_W-1:0] RISE_RST = 8'sd15;
    localparam logic signed [THR_W-1:0] FALL_RST = -8'sd10;
    localparam logic [THR_W-1:0]        HOLD_RST = 8'd30;
    localparam logic [THR_W-1:0]        TURN_RST = 8'd45;

    typedef struct packed {
        logic signed [RAW_W-1:0] roll_rate_raw;
        logic signed [RAW_W-1:0] yaw_rate_raw;
    } t_in_word;

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic              stepping;
        logic              step_start;
        logic              step_end;
    } t_out_word;

    typedef struct packed {
        logic signed [OFF_W-1:0] roll_offset;
        logic signed [OFF_W-1:0] yaw_offset;
        logic signed [THR_W-1:0] rise_threshold;
        logic signed [THR_W-1:0] fall_threshold;
        logic [THR_W-1:0]        holdoff_ticks;
        logic [THR_W-1:0]        turn_threshold;
    } t_cfg;

    typedef struct packed {
        logic rd;
        logic upd;
        logic mul;
        logic div;
        logic scl;
        logic rnd;
        logic itg;
        logic fin;
    } t_seq_ctl;

    function automatic logic signed [PROD_W-1:0] scale_mult(input logic signed [RD_W-1:0] d);
        return PROD_W'(d) * PROD_W'(SCALE_Q12);
    endfunction

    // Rounds a Q.20 product half away from zero back to Q.8.
    function automatic logic signed [RS_W-1:0] scale_round(input logic signed [PROD_W-1:0] x);
        logic [PROD_W-1:0]       mag;
        logic [PROD_W-1:0]       sum;
        logic signed [RS_W-1:0]  res;
        mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
        sum = mag + PROD_W'(1 << (SCALE_SH - 1));
        res = $signed(sum[SCALE_SH +: RS_W]);
        return x[PROD_W-1] ? -res : res;
    endfunction

endpackage

>>> rtl/gshd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module gshd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 40
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]        i_wdata,
    input  logic                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gshd_avg.sv
// Moving-average unit: window memory read-modify-write, running totals and a
// reciprocal divide by the window length. Uses gshd_pkg and gshd_ram.
module gshd_avg #(
    parameter int WINDOW_LEN = 40
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gshd_pkg::t_seq_ctl                   i_ctl,
    input  logic signed [gshd_pkg::SMP_W-1:0]    i_roll_smp,
    input  logic signed [gshd_pkg::SMP_W-1:0]    i_yaw_smp,
    output logic signed [gshd_pkg::AVG_W-1:0]    o_roll_avg,
    output logic signed [gshd_pkg::AVG_W-1:0]    o_yaw_avg
);

    localparam int SMP_W = gshd_pkg::SMP_W;
    localparam int Q_W   = gshd_pkg::Q_W;
    localparam int AVG_W = gshd_pkg::AVG_W;
    localparam int PW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOT_W = $clog2(WINDOW_LEN * gshd_pkg::SMP_MAG + 1) + 1;
    localparam int MAG_W = TOT_W - 1 + gshd_pkg::FRAC_W;
    localparam int SH    = MAG_W;

    localparam logic [SH:0]    RECIP = (SH + 1)'((2 ** SH) / WINDOW_LEN);
    localparam logic [MAG_W:0] WL    = (MAG_W + 1)'(WINDOW_LEN);
    localparam logic [PW-1:0]  LAST  = PW'(WINDOW_LEN - 1);

    logic [PW-1:0]            r_pos;
    logic [WINDOW_LEN-1:0]    r_vld;
    logic                     r_old_vld;
    logic [2*SMP_W-1:0]       rdata;
    logic signed [TOT_W-1:0]  r_tot [2];
    logic signed [TOT_W-1:0]  n_tot [2];
    logic signed [SMP_W-1:0]  smp [2];
    logic signed [SMP_W-1:0]  old [2];
    logic [TOT_W-2:0]         absv [2];
    logic [MAG_W-1:0]         mag [2];
    logic [MAG_W+SH:0]        prod [2];
    logic [MAG_W-1:0]         r_mag [2];
    logic                     r_neg [2];
    logic [Q_W-1:0]           r_q [2];
    logic [MAG_W:0]           rem [2];
    logic [Q_W-1:0]           q [2];
    logic signed [AVG_W-1:0]  r_avg [2];

    gshd_ram #(
        .WIDTH (2 * SMP_W),
        .DEPTH (WINDOW_LEN)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd),
        .i_waddr (r_pos),
        .i_wdata ({i_roll_smp, i_yaw_smp}),
        .i_re    (i_ctl.rd),
        .i_raddr (r_pos),
        .o_rdata (rdata)
    );

    always_comb begin
        smp[0] = i_roll_smp;
        smp[1] = i_yaw_smp;
        old[0] = r_old_vld ? $signed(rdata[2*SMP_W-1:SMP_W]) : '0;
        old[1] = r_old_vld ? $signed(rdata[SMP_W-1:0]) : '0;
        for (int a = 0; a < 2; a++) begin
            n_tot[a] = r_tot[a] + {{(TOT_W-SMP_W){smp[a][SMP_W-1]}}, smp[a]}
                       - {{(TOT_W-SMP_W){old[a][SMP_W-1]}}, old[a]};
            absv[a]  = r_tot[a][TOT_W-1] ? (TOT_W-1)'(-r_tot[a]) : (TOT_W-1)'(r_tot[a]);
            mag[a]   = {absv[a], {gshd_pkg::FRAC_W{1'b0}}};
            prod[a]  = {{(SH+1){1'b0}}, mag[a]} * {{MAG_W{1'b0}}, RECIP};
            rem[a]   = {1'b0, r_mag[a]} - ({{(MAG_W+1-Q_W){1'b0}}, r_q[a]} * WL);
            q[a]     = r_q[a] + Q_W'(rem[a] >= WL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_vld    <= '0;
            r_tot[0] <= '0;
            r_tot[1] <= '0;
        end else if (i_ctl.upd) begin
            r_pos        <= (r_pos == LAST) ? '0 : r_pos + 1'b1;
            r_vld[r_pos] <= 1'b1;
            r_tot[0]     <= n_tot[0];
            r_tot[1]     <= n_tot[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_old_vld <= r_vld[r_pos];
        end
        for (int a = 0; a < 2; a++) begin
            if (i_ctl.mul) begin
                r_mag[a] <= mag[a];
                r_neg[a] <= r_tot[a][TOT_W-1];
                r_q[a]   <= prod[a][SH +: Q_W];
            end
            if (i_ctl.div) begin
                r_avg[a] <= r_neg[a] ? -$signed({1'b0, q[a]}) : $signed({1'b0, q[a]});
            end
        end
    end

    assign o_roll_avg = r_avg[0];
    assign o_yaw_avg  = r_avg[1];

endmodule

>>> rtl/gshd_step.sv
// Roll path: offset removal, scaling and the two-phase step detector with
// holdoff. Uses gshd_pkg.
module gshd_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gshd_pkg::t_seq_ctl                i_ctl,
    input  gshd_pkg::t_cfg                    i_cfg,
    input  logic signed [gshd_pkg::AVG_W-1:0] i_roll_avg,
    output logic                              o_stepping,
    output logic                              o_step_start,
    output logic                              o_step_end
);

    typedef enum logic [1:0] {
        PH_STANDING = 2'b01,
        PH_STEPPING = 2'b10
    } t_phase;

    localparam int RD_W   = gshd_pkg::RD_W;
    localparam int PROD_W = gshd_pkg::PROD_W;
    localparam int RS_W   = gshd_pkg::RS_W;
    localparam int THR_W  = gshd_pkg::THR_W;

    logic signed [RD_W-1:0]   rd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RS_W-1:0]   r_rs;
    logic signed [RS_W-1:0]   rise;
    logic signed [RS_W-1:0]   fall;
    t_phase                   r_phase;
    t_phase                   n_phase;
    logic [THR_W-1:0]         r_hold;
    logic [THR_W-1:0]         n_hold;

    always_comb begin
        rd   = RD_W'(i_roll_avg) - RD_W'($signed(i_cfg.roll_offset));
        rise = $signed({i_cfg.rise_threshold, {gshd_pkg::FRAC_W{1'b0}}});
        fall = $signed({i_cfg.fall_threshold, {gshd_pkg::FRAC_W{1'b0}}});
        n_phase      = r_phase;
        n_hold       = r_hold;
        o_step_start = 1'b0;
        o_step_end   = 1'b0;
        if (r_hold != '0) begin
            n_hold = r_hold - 1'b1;
        end else begin
            case (r_phase)
                PH_STANDING: begin
                    if (r_rs > rise) begin
                        n_phase      = PH_STEPPING;
                        n_hold       = i_cfg.holdoff_ticks;
                        o_step_start = 1'b1;
                    end
                end
                PH_STEPPING: begin
                    if (r_rs < fall) begin
                        n_phase    = PH_STANDING;
                        n_hold     = i_cfg.holdoff_ticks;
                        o_step_end = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_STANDING;
                end
            endcase
        end
        o_stepping = (n_phase == PH_STEPPING);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scl) begin
            r_prod <= gshd_pkg::scale_mult(rd);
        end
        if (i_ctl.rnd) begin
            r_rs <= gshd_pkg::scale_round(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STANDING;
            r_hold  <= '0;
        end else if (i_ctl.fin) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
        end
    end

endmodule

>>> rtl/gshd_yaw.sv
// Yaw path: signed offset removal, scaling, weighted history integration and
// the eight-way heading counter. Uses gshd_pkg.
module gshd_yaw (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gshd_pkg::t_seq_ctl                 i_ctl,
    input  gshd_pkg::t_cfg                     i_cfg,
    input  logic signed [gshd_pkg::AVG_W-1:0]  i_yaw_avg,
    output logic [gshd_pkg::HEAD_W-1:0]        o_heading
);

    localparam int AVG_W   = gshd_pkg::AVG_W;
    localparam int RD_W    = gshd_pkg::RD_W;
    localparam int PROD_W  = gshd_pkg::PROD_W;
    localparam int RS_W    = gshd_pkg::RS_W;
    localparam int FRAC_W  = gshd_pkg::FRAC_W;
    localparam int WH_W    = 8;
    localparam int TERM_W  = 18;
    localparam int IPROD_W = 41;
    localparam int ISH     = 24;
    localparam int INC_W   = 17;
    localparam int INT_W   = 26;
    localparam int TC_W    = 4;

    localparam logic signed [24:0]     DT6     = 25'(gshd_pkg::DT6_Q32);
    localparam logic signed [TC_W-1:0] TC_WRAP = 4'sb1000;

    logic signed [RD_W-1:0]    yd;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [RS_W-1:0]    ys;
    logic signed [WH_W-1:0]    ywhole;
    logic signed [TERM_W-1:0]  term;
    logic signed [TERM_W-1:0]  r_term;
    logic signed [WH_W-1:0]    r_ywhole;
    logic signed [IPROD_W-1:0] r_iprod;
    logic [IPROD_W-1:0]        imag;
    logic [IPROD_W-1:0]        isum;
    logic signed [INC_W-1:0]   inc;
    logic signed [INT_W-1:0]   thr;
    logic signed [INT_W-1:0]   n_int;
    logic signed [INT_W-1:0]   r_int;
    logic signed [TC_W-1:0]    n_tc;
    logic signed [TC_W-1:0]    r_tc;
    logic signed [WH_W-1:0]    r_hist [3];
    logic [1:0]                r_fill;

    always_comb begin
        if (!i_yaw_avg[AVG_W-1] && (i_yaw_avg != '0)) begin
            yd = RD_W'(i_yaw_avg) - RD_W'($signed(i_cfg.yaw_offset));
        end else begin
            yd = RD_W'(i_yaw_avg) + RD_W'($signed(i_cfg.yaw_offset));
        end

        ys     = gshd_pkg::scale_round(r_prod);
        ywhole = WH_W'(ys >>> FRAC_W)
                 + WH_W'(ys[RS_W-1] && (ys[FRAC_W-1:0] != '0));
        term   = (TERM_W'(r_hist[0]) <<< 8) + (TERM_W'(r_hist[1]) <<< 9)
                 + (TERM_W'(r_hist[2]) <<< 9) + TERM_W'(ys);

        imag = r_iprod[IPROD_W-1] ? IPROD_W'(-r_iprod) : IPROD_W'(r_iprod);
        isum = imag + IPROD_W'(1 << (ISH - 1));
        inc  = r_iprod[IPROD_W-1] ? -$signed({1'b0, isum[ISH +: INC_W-1]})
                                  : $signed({1'b0, isum[ISH +: INC_W-1]});

        thr   = $signed({2'b00, i_cfg.turn_threshold, 16'h0000});
        n_int = r_int + INT_W'(inc);
        n_tc  = r_tc;
        if (n_int > thr) begin
            n_tc  = r_tc + 4'sd1;
            n_int = '0;
        end else if (n_int < -thr) begin
            n_tc  = r_tc - 4'sd1;
            n_int = '0;
        end
        // Plus eight and minus eight both come out as minus eight in four bits.
        if (n_tc == TC_WRAP) begin
            n_tc = '0;
        end
        o_heading = n_tc[gshd_pkg::HEAD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scl) begin
            r_prod <= gshd_pkg::scale_mult(yd);
        end
        if (i_ctl.rnd) begin
            r_term   <= term;
            r_ywhole <= ywhole;
        end
        if (i_ctl.itg) begin
            r_iprod <= r_term * DT6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int     <= '0;
            r_tc      <= '0;
            r_fill    <= '0;
            r_hist[0] <= '0;
            r_hist[1] <= '0;
            r_hist[2] <= '0;
        end else if (i_ctl.fin) begin
            r_int <= n_int;
            r_tc  <= n_tc;
            if (r_fill < 2'd3) begin
                r_hist[r_fill] <= r_ywhole;
                r_fill         <= r_fill + 2'd1;
            end else begin
                r_hist[0] <= r_hist[1];
                r_hist[1] <= r_hist[2];
                r_hist[2] <= r_ywhole;
            end
        end
    end

endmodule

>>> rtl/gyro_step_and_heading_detector.sv
// Top level of the gyro step and heading detector: sequencer, configuration
// registers and output register. Uses gshd_pkg, gshd_avg, gshd_step, gshd_yaw.
//
// Each accepted word carries one raw roll and one raw yaw gyro sample and
// produces exactly one result word: the eight-way heading and the step
// detector flags. The result of a word is registered after the fixed sequence
// of window memory read, total update and write-back, the two steps of the
// reciprocal divide, the scaling multiply, rounding, the integration multiply
// and the final commit. The next word is taken only once the final commit is
// done, so a new word is not accepted while the previous one is in progress.
// A finished result waits in the output register while the next word is
// taken; the final step waits only if the previous result is still held.
// The window memory needs no clearing pass: entries not yet written read as
// zero through per-entry valid bits. Write configuration only while idle.
module gyro_step_and_heading_detector #(
    parameter int WINDOW_LEN = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gshd_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gshd_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [gshd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gshd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_UPD  = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_DIV  = 8'b0000_1000,
        ST_SCL  = 8'b0001_0000,
        ST_RND  = 8'b0010_0000,
        ST_ITG  = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } t_state;

    localparam int SMP_W = gshd_pkg::SMP_W;
    localparam int RAW_W = gshd_pkg::RAW_W;

    t_state                           r_state;
    t_state                           n_state;
    gshd_pkg::t_seq_ctl               ctl;
    gshd_pkg::t_cfg                   r_cfg;
    gshd_pkg::t_out_word              r_out_word;
    logic                             r_out_valid;
    logic                             in_acc;
    logic                             out_free;
    logic signed [SMP_W-1:0]          r_roll_smp;
    logic signed [SMP_W-1:0]          r_yaw_smp;
    logic signed [gshd_pkg::AVG_W-1:0] roll_avg;
    logic signed [gshd_pkg::AVG_W-1:0] yaw_avg;
    logic [gshd_pkg::HEAD_W-1:0]      heading;
    logic                             stepping;
    logic                             step_start;
    logic                             step_end;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        ctl.rd  = in_acc;
        ctl.upd = (r_state == ST_UPD);
        ctl.mul = (r_state == ST_MUL);
        ctl.div = (r_state == ST_DIV);
        ctl.scl = (r_state == ST_SCL);
        ctl.rnd = (r_state == ST_RND);
        ctl.itg = (r_state == ST_ITG);
        ctl.fin = (r_state == ST_FIN) && out_free;

        case (r_state)
            ST_IDLE: n_state = in_acc ? ST_UPD : ST_IDLE;
            ST_UPD:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  n_state = ST_SCL;
            ST_SCL:  n_state = ST_RND;
            ST_RND:  n_state = ST_ITG;
            ST_ITG:  n_state = ST_FIN;
            ST_FIN:  n_state = out_free ? ST_IDLE : ST_FIN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_roll_smp <= i_in_word.roll_rate_raw[RAW_W-1 -: SMP_W];
            r_yaw_smp  <= i_in_word.yaw_rate_raw[RAW_W-1 -: SMP_W];
        end
        if (ctl.fin) begin
            r_out_word.heading    <= heading;
            r_out_word.stepping   <= stepping;
            r_out_word.step_start <= step_start;
            r_out_word.step_end   <= step_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roll_offset    <= '0;
            r_cfg.yaw_offset     <= '0;
            r_cfg.rise_threshold <= gshd_pkg::RISE_RST;
            r_cfg.fall_threshold <= gshd_pkg::FALL_RST;
            r_cfg.holdoff_ticks  <= gshd_pkg::HOLD_RST;
            r_cfg.turn_threshold <= gshd_pkg::TURN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gshd_pkg::CFG_ROLL_OFFSET:    r_cfg.roll_offset    <= i_cfg_data;
                gshd_pkg::CFG_YAW_OFFSET:     r_cfg.yaw_offset     <= i_cfg_data;
                gshd_pkg::CFG_RISE_THRESHOLD: r_cfg.rise_threshold <= i_cfg_data[7:0];
                gshd_pkg::CFG_FALL_THRESHOLD: r_cfg.fall_threshold <= i_cfg_data[7:0];
                gshd_pkg::CFG_HOLDOFF_TICKS:  r_cfg.holdoff_ticks  <= i_cfg_data[7:0];
                gshd_pkg::CFG_TURN_THRESHOLD: r_cfg.turn_threshold <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    gshd_avg #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_roll_smp (r_roll_smp),
        .i_yaw_smp  (r_yaw_smp),
        .o_roll_avg (roll_avg),
        .o_yaw_avg  (yaw_avg)
    );

    gshd_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_cfg        (r_cfg),
        .i_roll_avg   (roll_avg),
        .o_stepping   (stepping),
        .o_step_start (step_start),
        .o_step_end   (step_end)
    );

    gshd_yaw u_yaw (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_cfg     (r_cfg),
        .i_yaw_avg (yaw_avg),
        .o_heading (heading)
    );

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_UPD))
        else $error("accepted word did not start the update step");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && out_free) |=> (o_out_valid && (r_state == ST_IDLE)))
        else $error("committed result not presented");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && r_out_valid && i_out_stall)
        |=> ((r_state == ST_FIN) && $stable(o_out_word)))
        else $error("result overwritten while the previous word was held");

endmodule

>>> tb/sv/gyro_step_and_heading_detector_tb.sv
// Self-checking testbench for gyro_step_and_heading_detector: a cycle-free
// tracker class predicts heading and step flags per accepted word.
// Depends on gshd_pkg and the detector RTL only.
`timescale 1ns / 100ps

module gyro_step_and_heading_detector_tb;

    localparam int WINDOW          = 40;
    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LONG_HOLD       = 300;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int CFG_IDX_W       = gshd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = gshd_pkg::CFG_DATA_W;
    localparam int THR_W           = gshd_pkg::THR_W;
    localparam longint LIMIT_NS    = 64'd5_000_000;

    class heading_step_tracker;
        int roll_win[WINDOW];
        int yaw_win[WINDOW];
        int win_pos;
        int roll_total;
        int yaw_total;
        int yaw_hist[3];
        int hist_fill;
        int yaw_integral;
        int turn_count;
        bit stepping;
        int holdoff_left;
        int roll_off;
        int yaw_off;
        int rise_thr;
        int fall_thr;
        int holdoff_ticks;
        int turn_thr;
        int errors;
        gshd_pkg::t_out_word expected_flags[$];

        function new();
            rise_thr      = int'(gshd_pkg::RISE_RST);
            fall_thr      = int'(gshd_pkg::FALL_RST);
            holdoff_ticks = int'(gshd_pkg::HOLD_RST);
            turn_thr      = int'(gshd_pkg::TURN_RST);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                gshd_pkg::CFG_ROLL_OFFSET:    roll_off      = int'($signed(d));
                gshd_pkg::CFG_YAW_OFFSET:     yaw_off       = int'($signed(d));
                gshd_pkg::CFG_RISE_THRESHOLD: rise_thr      = int'($signed(d[THR_W-1:0]));
                gshd_pkg::CFG_FALL_THRESHOLD: fall_thr      = int'($signed(d[THR_W-1:0]));
                gshd_pkg::CFG_HOLDOFF_TICKS:  holdoff_ticks = int'(d[THR_W-1:0]);
                gshd_pkg::CFG_TURN_THRESHOLD: turn_thr      = int'(d[THR_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint round_half_away(longint x, int s);
            longint mag;
            mag = (x < 0) ? -x : x;
            mag = (mag + (longint'(1) << (s - 1))) >>> s;
            return (x < 0) ? -mag : mag;
        endfunction

        function void take_sample(gshd_pkg::t_in_word w);
            int r, y, ravg, yavg, rd, yd, rs, ys, ywhole, lim;
            longint term;
            gshd_pkg::t_out_word o;
            r = int'($signed(w.roll_rate_raw)) >>> 11;
            y = int'($signed(w.yaw_rate_raw)) >>> 11;
            roll_total += r - roll_win[win_pos];
            roll_win[win_pos] = r;
            yaw_total += y - yaw_win[win_pos];
            yaw_win[win_pos] = y;
            win_pos = (win_pos + 1) % WINDOW;
            ravg = (roll_total * 256) / WINDOW;
            yavg = (yaw_total * 256) / WINDOW;

            rd = ravg - roll_off;
            yd = (yavg > 0) ? yavg - yaw_off : yavg + yaw_off;
            rs = int'(round_half_away(longint'(rd) * longint'(gshd_pkg::SCALE_Q12),
                                      gshd_pkg::SCALE_SH));
            ys = int'(round_half_away(longint'(yd) * longint'(gshd_pkg::SCALE_Q12),
                                      gshd_pkg::SCALE_SH));
            ywhole = ys / 256;

            term = longint'(yaw_hist[0]) * 256 + longint'(yaw_hist[1]) * 512 +
                   longint'(yaw_hist[2]) * 512 + longint'(ys);
            yaw_integral += int'(round_half_away(term * longint'(gshd_pkg::DT6_Q32), 24));
            if (hist_fill < 3) begin
                yaw_hist[hist_fill] = ywhole;
                hist_fill++;
            end else begin
                yaw_hist[0] = yaw_hist[1];
                yaw_hist[1] = yaw_hist[2];
                yaw_hist[2] = ywhole;
            end

            lim = turn_thr * 65536;
            if (yaw_integral > lim) begin
                turn_count++;
                yaw_integral = 0;
            end else if (yaw_integral < -lim) begin
                turn_count--;
                yaw_integral = 0;
            end
            if (turn_count == 8 || turn_count == -8) begin
                turn_count = 0;
            end

            o.step_start = 1'b0;
            o.step_end   = 1'b0;
            if (holdoff_left != 0) begin
                holdoff_left--;
            end else if (!stepping) begin
                if (rs > rise_thr * 256) begin
                    stepping     = 1'b1;
                    holdoff_left = holdoff_ticks;
                    o.step_start = 1'b1;
                end
            end else begin
                if (rs < fall_thr * 256) begin
                    stepping     = 1'b0;
                    holdoff_left = holdoff_ticks;
                    o.step_end   = 1'b1;
                end
            end
            o.heading  = 3'(turn_count & 7);
            o.stepping = stepping;
            expected_flags.push_back(o);
        endfunction

        function void note_mismatch(string field, logic [2:0] want, logic [2:0] got);
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_flags(gshd_pkg::t_out_word got);
            gshd_pkg::t_out_word want;
            if (expected_flags.size() == 0) begin
                errors++;
                $display("%0t: result word %h arrived with none expected", $time, got);
                return;
            end
            want = expected_flags.pop_front();
            if (got.heading !== want.heading) begin
                note_mismatch("heading", want.heading, got.heading);
            end
            if (got.stepping !== want.stepping) begin
                note_mismatch("stepping", 3'(want.stepping), 3'(got.stepping));
            end
            if (got.step_start !== want.step_start) begin
                note_mismatch("step_start", 3'(want.step_start), 3'(got.step_start));
            end
            if (got.step_end !== want.step_end) begin
                note_mismatch("step_end", 3'(want.step_end), 3'(got.step_end));
            end
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    gshd_pkg::t_in_word    i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    gshd_pkg::t_out_word   o_out_word;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    heading_step_tracker tracker = new();
    bit calm     = 1'b0;
    bit gappy    = 1'b0;
    bit hold_req = 1'b0;
    int seg_left = 0;
    int seg_roll = 0;
    int seg_yaw  = 0;
    bit seg_noise = 1'b0;

    gyro_step_and_heading_detector #(
        .WINDOW_LEN(WINDOW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                tracker.take_sample(i_in_word);
            end
            if (o_out_valid && !i_out_stall) begin
                tracker.check_flags(o_out_word);
            end
        end
    end

    initial begin : result_side
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat (calm ? 1 : $urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_tick(input gshd_pkg::t_in_word w);
        int gap;
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        gap = 0;
        if (!calm && gappy && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 13);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        tracker.write_reg(idx, CFG_DATA_W'(value));
        @(posedge i_clk);
    endtask

    task automatic configure(input int roll_off, input int yaw_off, input int rise,
                             input int fall, input int hold, input int turn);
        set_reg(gshd_pkg::CFG_ROLL_OFFSET, roll_off);
        set_reg(gshd_pkg::CFG_YAW_OFFSET, yaw_off);
        set_reg(gshd_pkg::CFG_RISE_THRESHOLD, rise);
        set_reg(gshd_pkg::CFG_FALL_THRESHOLD, fall);
        set_reg(gshd_pkg::CFG_HOLDOFF_TICKS, hold);
        set_reg(gshd_pkg::CFG_TURN_THRESHOLD, turn);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Most words come in segments of steady gyro levels with random low bits,
    // long enough to move the window averages; some segments are pure noise.
    task automatic run_phase(input int count, input bit squeeze);
        gshd_pkg::t_in_word w;
        int rl, yl;
        if (squeeze) begin
            hold_req = 1'b1;
        end
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                gappy = $urandom_range(0, 1);
            end
            if (seg_left == 0) begin
                seg_left  = $urandom_range(10, 80);
                seg_roll  = int'($urandom_range(0, 31)) - 16;
                seg_yaw   = int'($urandom_range(0, 31)) - 16;
                seg_noise = ($urandom_range(0, 4) == 0);
            end
            seg_left--;
            if (seg_noise) begin
                w = $urandom;
            end else begin
                rl = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 31)) : seg_roll;
                yl = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 31)) : seg_yaw;
                w.roll_rate_raw = {5'(rl), 11'($urandom)};
                w.yaw_rate_raw  = {5'(yl), 11'($urandom)};
            end
            send_tick(w);
        end
    endtask

    initial begin : stimulus
        int corner_roll[8] = '{-32768, 32767, 0, -1, 2047, 2048, -2048, -2049};
        int corner_yaw[8]  = '{32767, -32768, 0, -1, 2048, 2047, -2049, -2048};
        gshd_pkg::t_in_word w;
        int rise, fall, hold, turn;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 8; k++) begin
            w.roll_rate_raw = 16'(corner_roll[k]);
            w.yaw_rate_raw  = 16'(corner_yaw[k]);
            send_tick(w);
        end
        for (int k = 0; k < 16; k++) begin
            w.roll_rate_raw = 16'sh7fff;
            w.yaw_rate_raw  = 16'sh7fff;
            send_tick(w);
        end
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(-4096, 3840, -128, 127, 0, 1);
                1: configure(3840, -4096, 127, -128, 255, 255);
                2: configure(4095, 4095, 5, -5, 3, 0);
                default: begin
                    rise = $urandom_range(0, 1) ? int'($urandom_range(0, 255)) - 128
                                                : int'($urandom_range(0, 30));
                    fall = $urandom_range(0, 1) ? int'($urandom_range(0, 255)) - 128
                                                : -int'($urandom_range(0, 30));
                    hold = ($urandom_range(0, 3) == 0) ? 255 : int'($urandom_range(0, 40));
                    turn = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 255))
                                                       : int'($urandom_range(1, 12));
                    configure(int'($urandom_range(0, 7936)) - 4096,
                              int'($urandom_range(0, 7936)) - 4096, rise, fall, hold, turn);
                end
            endcase
            calm = (p == PHASES - 1);
            run_phase(ITEMS_PER_PHASE, p == 3);
            settle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/gshd_pkg.sv
rtl/gshd_ram.sv
rtl/gshd_avg.sv
rtl/gshd_step.sv
rtl/gshd_yaw.sv
rtl/gyro_step_and_heading_detector.sv
tb/sv/gyro_step_and_heading_detector_tb.sv
